[rtl/core/rde_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rde_pkg;

	localparam int MAX_SYMBOLS = 16;
	localparam int MAX_DIGITS  = 32;

	localparam int VALUE_W    = 32;
	localparam int SYM_W      = 8;
	localparam int RADIX_W    = 5;
	localparam int ALPHA_SIZE = 16;
	localparam int IDX_W      = $clog2(ALPHA_SIZE);
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;

	localparam int DIV_STEPS = 8;
	localparam int CHUNKS    = VALUE_W / DIV_STEPS;
	localparam int CHUNK_W   = $clog2(CHUNKS);

	localparam int SP_W   = $clog2(MAX_DIGITS + 1);
	localparam int ADDR_W = $clog2(MAX_DIGITS);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHABET_LOW  = 2'd0,
		REG_ALPHABET_HIGH = 2'd1,
		REG_RADIX         = 2'd2
	} reg_idx_t;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef struct packed {
		logic [ALPHA_SIZE-1:0][SYM_W-1:0] symbols;
		logic [RADIX_W-1:0]               radix;
		logic                             ok;
	} cfg_t;

	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

[rtl/core/rde_value_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rde_value_if;
	logic            valid;
	logic            ready;
	rde_pkg::value_t value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

[rtl/core/rde_symbol_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rde_symbol_if;
	logic                        valid;
	logic                        ready;
	logic [rde_pkg::SYM_W-1:0]   symbol;
	logic                        last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink (input valid, input symbol, input last, output ready);
endinterface

`default_nettype wire

[rtl/core/rde_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rde_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rde_pkg::CFG_IDX_W-1:0]  index;
	logic [rde_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/radix_digit_emitter.sv]
`timescale 1ns / 1ps
`default_nettype none

// Converts a signed 32-bit number to text in a programmable radix of 2 to 16.
// Three channels, each with valid and ready: number carries one value per item,
// text returns one symbol byte per item with last set on the final symbol, and
// cfg writes the registers (0: symbols 0 to 7, 1: symbols 8 to 15, 2: radix).
// Write the registers only while no number is in flight.
// A negative number starts with a minus sign; zero gives symbol 0. With an
// invalid alphabet a number is taken and dropped without any text.
// Each digit takes a full pass through the shared divider, which retires eight
// quotient bits per cycle. The converter takes one number at a time and pops
// the next only after loading the last symbol of the current one.
// A two-entry queue holds numbers waiting for the converter, so the input keeps
// taking items while text drains. When the receiver stalls, the output register
// holds its symbol and the converter waits. Reset clears the configuration
// registers to zero, which leaves the alphabet invalid until it is written, and
// empties the queue.
module radix_digit_emitter (
	input  logic         clk,
	input  logic         arst_n,
	rde_value_if.sink    number,
	rde_symbol_if.source text,
	rde_cfg_if.sink      cfg
);
	import rde_pkg::*;

	cfg_t    cfg_state;
	q_stat_t q_stat;
	job_t    q_wdata;
	job_t    q_rdata;
	logic    q_push;
	logic    q_pop;

	rde_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cfg_state (cfg_state)
	);

	rde_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.number    (number),
		.cfg_state (cfg_state),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	rde_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	rde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_state (cfg_state),
		.q_stat    (q_stat),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.text      (text)
	);

	a_last_not_sign: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && text.last |-> text.symbol != SYM_MINUS)
		else $error("minus sign marked as last symbol");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue pop while empty");

endmodule

`default_nettype wire

[rtl/core/rde_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module rde_cfg (
	input  logic          clk,
	input  logic          arst_n,
	rde_cfg_if.sink       cfg,
	output rde_pkg::cfg_t cfg_state
);
	import rde_pkg::*;

	logic [CFG_DATA_W-1:0]            alpha_lo_q;
	logic [CFG_DATA_W-1:0]            alpha_hi_q;
	logic [RADIX_W-1:0]               radix_q;
	logic [ALPHA_SIZE-1:0][SYM_W-1:0] syms;
	logic                             bad;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_lo_q <= '0;
			alpha_hi_q <= '0;
			radix_q    <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ALPHABET_LOW:  alpha_lo_q <= cfg.data;
				REG_ALPHABET_HIGH: alpha_hi_q <= cfg.data;
				REG_RADIX:         radix_q    <= cfg.data[RADIX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign syms = {alpha_hi_q, alpha_lo_q};

	// The alphabet is usable only if the radix is 2 to 16, no symbol in use is zero,
	// a plus or a minus sign, and no two symbols in use are equal.
	always_comb begin
		bad = (radix_q < RADIX_W'(2)) || (radix_q > RADIX_W'(MAX_SYMBOLS));
		for (int a = 0; a < ALPHA_SIZE; a++) begin
			if (RADIX_W'(a) < radix_q) begin
				if (syms[a] == '0 || syms[a] == SYM_PLUS || syms[a] == SYM_MINUS) begin
					bad = 1'b1;
				end
				for (int b = a + 1; b < ALPHA_SIZE; b++) begin
					if (RADIX_W'(b) < radix_q && syms[a] == syms[b]) begin
						bad = 1'b1;
					end
				end
			end
		end
	end

	assign cfg_state.symbols = syms;
	assign cfg_state.radix   = radix_q;
	assign cfg_state.ok      = !bad;

endmodule

`default_nettype wire

[rtl/core/rde_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rde_front (
	input  logic             clk,
	input  logic             arst_n,
	rde_value_if.sink        number,
	input  rde_pkg::cfg_t    cfg_state,
	input  rde_pkg::q_stat_t q_stat,
	output logic             q_push,
	output rde_pkg::job_t    q_wdata
);
	import rde_pkg::*;

	logic               valid_s1;
	logic               keep_s1;
	job_t               job_s1;
	logic               advance;
	logic [VALUE_W-1:0] raw;

	assign raw     = number.value;
	assign advance = valid_s1 && (!keep_s1 || !q_stat.full);
	assign q_push  = valid_s1 && keep_s1 && !q_stat.full;
	assign q_wdata = job_s1;

	assign number.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			keep_s1  <= 1'b0;
		end else if (number.ready) begin
			valid_s1 <= number.valid;
			keep_s1  <= cfg_state.ok;
		end
	end

	// Sign and magnitude; the most negative value yields 2^31 unchanged.
	always_ff @(posedge clk) begin
		if (number.ready && number.valid) begin
			job_s1.neg <= raw[VALUE_W-1];
			job_s1.mag <= raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
		end
	end

endmodule

`default_nettype wire

[rtl/core/rde_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module rde_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rde_pkg::job_t     wdata,
	input  logic              pop,
	output rde_pkg::job_t     rdata,
	output rde_pkg::q_stat_t  stat
);
	import rde_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

[rtl/core/rde_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module rde_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rde_pkg::cfg_t    cfg_state,
	input  rde_pkg::q_stat_t q_stat,
	input  rde_pkg::job_t    q_rdata,
	output logic             q_pop,
	rde_symbol_if.source     text
);
	import rde_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t             state_q;
	logic [VALUE_W-1:0] dvd_q;
	logic [IDX_W-1:0]   rem_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic               neg_q;
	logic [SP_W-1:0]    sp_q;
	logic [IDX_W-1:0]   stack_q [MAX_DIGITS];
	logic               out_valid_q;
	logic [SYM_W-1:0]   out_symbol_q;
	logic               out_last_q;

	logic [VALUE_W-1:0] dvd_n;
	logic [IDX_W-1:0]   rem_n;
	logic               div_last;
	logic               load;
	logic [SP_W-1:0]    sp_m1;

	// Restoring division by the radix, several quotient bits per cycle. The
	// dividend register shifts out its top bits and collects the quotient.
	always_comb begin
		logic [IDX_W:0] t;
		dvd_n = dvd_q;
		rem_n = rem_q;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t     = {rem_n, dvd_n[VALUE_W-1]};
			dvd_n = {dvd_n[VALUE_W-2:0], 1'b0};
			if (t >= cfg_state.radix) begin
				rem_n    = IDX_W'(t - cfg_state.radix);
				dvd_n[0] = 1'b1;
			end else begin
				rem_n = t[IDX_W-1:0];
			end
		end
	end

	assign div_last = (chunk_q == CHUNK_W'(CHUNKS - 1));
	assign load     = (state_q == ST_EMIT) && (!out_valid_q || text.ready);
	assign sp_m1    = sp_q - SP_W'(1);
	assign q_pop    = (state_q == ST_IDLE) && !q_stat.empty;

	assign text.valid  = out_valid_q;
	assign text.symbol = out_symbol_q;
	assign text.last   = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chunk_q     <= '0;
			neg_q       <= 1'b0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (text.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						neg_q   <= q_rdata.neg;
						sp_q    <= '0;
						chunk_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					chunk_q <= chunk_q + CHUNK_W'(1);
					if (div_last) begin
						chunk_q <= '0;
						sp_q    <= sp_q + SP_W'(1);
						if (dvd_n == '0) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (load) begin
						if (neg_q) begin
							neg_q <= 1'b0;
						end else begin
							sp_q <= sp_m1;
							if (sp_q == SP_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			dvd_q <= q_rdata.mag;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q <= dvd_n;
			rem_q <= div_last ? '0 : rem_n;
			if (div_last) begin
				stack_q[sp_q[ADDR_W-1:0]] <= rem_n;
			end
		end
		if (load) begin
			if (neg_q) begin
				out_symbol_q <= SYM_MINUS;
				out_last_q   <= 1'b0;
			end else begin
				out_symbol_q <= cfg_state.symbols[stack_q[sp_m1[ADDR_W-1:0]]];
				out_last_q   <= (sp_q == SP_W'(1));
			end
		end
	end

endmodule

`default_nettype wire

[tb/radix_digit_emitter_checker.sv]
`timescale 1ns / 1ps

module radix_digit_emitter_checker
	import rde_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	rde_value_if  number,
	rde_symbol_if text,
	rde_cfg_if    cfg,
	output int    fail_count,
	output int    chars_owed
);

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} text_char_t;

	text_char_t                       expected_chars[$];
	text_char_t                       want_char;
	logic [ALPHA_SIZE-1:0][SYM_W-1:0] glyph_table;
	logic [RADIX_W-1:0]               base_reg;

	function automatic bit alphabet_usable();
		if (base_reg < 2 || base_reg > MAX_SYMBOLS)
			return 1'b0;
		for (int a = 0; a < base_reg; a++) begin
			if (glyph_table[a] == '0 || glyph_table[a] == SYM_PLUS || glyph_table[a] == SYM_MINUS)
				return 1'b0;
			for (int b = a + 1; b < base_reg; b++) begin
				if (glyph_table[b] == glyph_table[a])
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Digits are collected least significant first, then queued behind an optional sign.
	function automatic void spell_number(input value_t v);
		logic [VALUE_W-1:0] mag;
		logic [SYM_W-1:0]   digits[$];
		if (!alphabet_usable())
			return;
		mag = v;
		if (v[VALUE_W-1])
			mag = ~mag + 1'b1;
		do begin
			digits.push_front(glyph_table[mag % base_reg]);
			mag = mag / base_reg;
		end while (mag != 0);
		if (v[VALUE_W-1])
			expected_chars.push_back('{symbol: SYM_MINUS, last: 1'b0});
		for (int i = 0; i < digits.size(); i++)
			expected_chars.push_back('{symbol: digits[i], last: i == digits.size() - 1});
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			glyph_table = '0;
			base_reg    = '0;
			fail_count  = 0;
			expected_chars.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_ALPHABET_LOW:  glyph_table[7:0]  = cfg.data;
					REG_ALPHABET_HIGH: glyph_table[15:8] = cfg.data;
					REG_RADIX:         base_reg          = cfg.data[RADIX_W-1:0];
					default:           ;
				endcase
			end
			if (number.valid && number.ready)
				spell_number(number.value);
			if (text.valid && text.ready) begin
				if (expected_chars.size() == 0) begin
					note_failure($sformatf("unexpected symbol %h last %b", text.symbol, text.last));
				end else begin
					want_char = expected_chars.pop_front();
					if (text.symbol !== want_char.symbol || text.last !== want_char.last)
						note_failure($sformatf("expected symbol %h last %b, got symbol %h last %b",
							want_char.symbol, want_char.last, text.symbol, text.last));
				end
			end
		end
		chars_owed = expected_chars.size();
	end

endmodule

[tb/radix_digit_emitter_test.sv]
`timescale 1ns / 1ps

module radix_digit_emitter_test;
	import rde_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	bit   calm   = 1'b0;
	int   fail_count;
	int   chars_owed;

	rde_value_if  number_ch ();
	rde_symbol_if text_ch ();
	rde_cfg_if    cfg_ch ();

	radix_digit_emitter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number_ch),
		.text   (text_ch),
		.cfg    (cfg_ch)
	);

	radix_digit_emitter_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.number     (number_ch),
		.text       (text_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.chars_owed (chars_owed)
	);

	always #5 clk = ~clk;

	function automatic bit want_gap();
		return !calm && $urandom_range(99) < 24;
	endfunction

	initial begin
		text_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			text_ch.ready <= calm || $urandom_range(99) >= 24;
		end
	end

	task automatic send_value(input value_t v);
		while (want_gap()) begin
			number_ch.valid <= 1'b0;
			@(posedge clk);
		end
		number_ch.valid <= 1'b1;
		number_ch.value <= v;
		do @(posedge clk); while (!number_ch.ready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		while (want_gap())
			@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		number_ch.valid <= 1'b0;
		@(posedge clk);
		while (chars_owed != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic random_alphabet(input bit legal, input int n);
		logic [ALPHA_SIZE-1:0][SYM_W-1:0] tbl;
		logic [CFG_DATA_W-1:0]            rdx;
		logic [SYM_W-1:0]                 b;
		bit                               taken[256];
		int                               a;
		for (int k = 0; k < ALPHA_SIZE; k++)
			tbl[k] = SYM_W'($urandom_range(255));
		for (int k = 0; k < n; k++) begin
			do b = SYM_W'($urandom_range(255));
			while (b == '0 || b == SYM_PLUS || b == SYM_MINUS || taken[b]);
			taken[b] = 1'b1;
			tbl[k]   = b;
		end
		if (!legal) begin
			case ($urandom_range(3))
				0: n = $urandom_range(1);
				1: n = $urandom_range(31, 17);
				2: begin
					case ($urandom_range(2))
						0:       tbl[$urandom_range(n - 1)] = '0;
						1:       tbl[$urandom_range(n - 1)] = SYM_PLUS;
						default: tbl[$urandom_range(n - 1)] = SYM_MINUS;
					endcase
				end
				default: begin
					a = $urandom_range(n - 1);
					tbl[(a + 1 + $urandom_range(n - 2)) % n] = tbl[a];
				end
			endcase
		end
		rdx                = {$urandom, $urandom};
		rdx[RADIX_W-1:0]   = n[RADIX_W-1:0];
		write_reg(REG_ALPHABET_LOW, tbl[7:0]);
		write_reg(REG_ALPHABET_HIGH, tbl[15:8]);
		write_reg(REG_RADIX, rdx);
	endtask

	function automatic value_t pick_value();
		case ($urandom_range(6))
			0, 1, 2: return value_t'($urandom);
			3:       return value_t'($urandom) >>> $urandom_range(31);
			4:       return value_t'(int'($urandom_range(40)) - 20);
			5:       return $urandom_range(1) ? value_t'(32'h8000_0000) : value_t'(32'h7FFF_FFFF);
			default: return value_t'(32'h1 << $urandom_range(31)) - value_t'($urandom_range(2));
		endcase
	endfunction

	initial begin
		number_ch.valid <= 1'b0;
		number_ch.value <= '0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= '0;
		cfg_ch.data     <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The alphabet left by reset is invalid, so these items produce no text.
		send_value(value_t'(0));
		send_value(value_t'(-1));
		send_value(value_t'(32'h7FFF_FFFF));
		settle();

		// Decimal, with forbidden symbols parked in the unused slots.
		write_reg(REG_ALPHABET_LOW, 64'h3736_3534_3332_3130);
		write_reg(REG_ALPHABET_HIGH, 64'h2B2B_2B2B_2B2B_3938);
		write_reg(REG_RADIX, 64'd10);
		write_reg(REG_UNMAPPED, '1);
		send_value(value_t'(0));
		send_value(value_t'(7));
		send_value(value_t'(-10));
		send_value(value_t'(32'h7FFF_FFFF));
		send_value(value_t'(32'h8000_0000));
		send_value(value_t'(1000000));
		settle();

		// Binary gives the longest text.
		write_reg(REG_ALPHABET_LOW, 64'h2D2D_2D2D_2D2D_3130);
		write_reg(REG_RADIX, 64'd2);
		send_value(value_t'(32'h8000_0000));
		send_value(value_t'(32'h5555_5555));
		send_value(value_t'(-1));
		settle();

		write_reg(REG_ALPHABET_LOW, 64'hFE7F_802C_2A2E_FF01);
		write_reg(REG_ALPHABET_HIGH, 64'h1020_4008_0402_C0E0);
		write_reg(REG_RADIX, 64'd16);
		send_value(value_t'(32'h7FFF_FFFF));
		send_value(value_t'(32'h8000_0000));
		send_value(value_t'(32'hFEDC_BA98));
		send_value(value_t'(0));
		settle();

		write_reg(REG_RADIX, 64'd1);
		send_value(value_t'(5));
		settle();
		write_reg(REG_RADIX, 64'd31);
		send_value(value_t'(5));
		settle();
		write_reg(REG_RADIX, 64'd16);
		write_reg(REG_ALPHABET_HIGH, 64'h2B20_4008_0402_C0E0);
		send_value(value_t'(5));
		settle();
		write_reg(REG_ALPHABET_HIGH, 64'h1020_4008_0402_00E0);
		send_value(value_t'(5));
		settle();
		write_reg(REG_ALPHABET_HIGH, 64'h1020_4001_0402_C0E0);
		send_value(value_t'(5));
		settle();
		write_reg(REG_ALPHABET_HIGH, 64'h1020_4008_0402_C0E0);
		write_reg(REG_ALPHABET_LOW, 64'hFE7F_802C_2A2E_FF2D);
		send_value(value_t'(5));
		settle();

		for (int p = 0; p < 10; p++) begin
			calm = (p == 4 || p == 5);
			random_alphabet(!(p > 1 && $urandom_range(4) == 0),
				p == 0 ? 2 : (p == 1 ? 16 : $urandom_range(16, 2)));
			repeat (21) send_value(pick_value());
			settle();
		end

		if (fail_count == 0 && chars_owed == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
